// File: design/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg: shared types and constants for the first-fit aligned allocator
// Holds the chunk record, the command broadcast to the cell chain, the
// controller states and the operation and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package ffa_pkg;

  // Table depth and address width.
  localparam int MAX_CHUNKS = 256;
  localparam int ADDR_W     = 32;
  localparam int IDX_W      = $clog2(MAX_CHUNKS);
  localparam int CNT_W      = IDX_W + 1;

  // Pool size after reset.
  localparam logic [ADDR_W-1:0] POOL_RESET = ADDR_W'(65536);

  // Operation codes.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Status codes.
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NO_FIT    = 2'd1;
  localparam logic [1:0] STAT_NOT_ALLOC = 2'd2;
  localparam logic [1:0] STAT_FULL      = 2'd3;

  // One table entry.
  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] length;
    logic              is_free;
  } chunk_t;

  localparam chunk_t CHUNK_EMPTY = '0;

  // What every cell does in a cycle.
  typedef enum logic [2:0] {
    CM_HOLD,
    CM_ROT,
    CM_INS,
    CM_REM,
    CM_INIT
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t        mode;
    logic              rem_from_one;
    logic [CNT_W-1:0]  lim;
    logic              wr_prev;
    logic              wr_cur;
    logic              wr_next;
    chunk_t            prev_val;
    chunk_t            cur_val;
    chunk_t            next_val;
    logic [ADDR_W-1:0] pool;
  } cell_cmd_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EDIT,
    ST_MERGE,
    ST_DONE
  } ffa_state_t;

endpackage

`default_nettype wire

// File: design/ffa_cell.sv
// ----------------------------------------------------------------------------
// ffa_cell: one slot of the chunk ring
// Holds one table entry and loads from a neighbor when the ring rotates or
// when an entry is inserted or removed, or takes a value written by the
// controller at the three slots around the head; a pool write reinitializes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_cell
  import ffa_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [IDX_W-1:0] cell_index,
  input  wire cell_cmd_t        cmd,
  input  wire chunk_t           left_entry,
  input  wire chunk_t           right_entry,
  output chunk_t                entry
);

  chunk_t           entry_next;
  logic [CNT_W-1:0] idx_ext;
  logic [CNT_W-1:0] rem_low;
  chunk_t           first_entry;
  chunk_t           home_entry;

  assign idx_ext = {1'b0, cell_index};
  assign rem_low = {{(CNT_W-1){1'b0}}, cmd.rem_from_one};

  // Shift or load, then the controller writes win.
  always_comb begin
    first_entry = CHUNK_EMPTY;
    first_entry.length = cmd.pool;
    first_entry.is_free = 1'b1;
    home_entry = CHUNK_EMPTY;
    home_entry.length = POOL_RESET;
    home_entry.is_free = 1'b1;
    entry_next = entry;
    unique case (cmd.mode)
      CM_HOLD: begin
        entry_next = entry;
      end
      CM_ROT: begin
        entry_next = right_entry;
      end
      CM_INS: begin
        if (idx_ext >= CNT_W'(2) && idx_ext <= cmd.lim) begin
          entry_next = left_entry;
        end
      end
      CM_REM: begin
        if (idx_ext == cmd.lim) begin
          entry_next = CHUNK_EMPTY;
        end else if (idx_ext >= rem_low && idx_ext < cmd.lim) begin
          entry_next = right_entry;
        end
      end
      CM_INIT: begin
        entry_next = (cell_index == '0) ? first_entry : CHUNK_EMPTY;
      end
      default: begin
        entry_next = entry;
      end
    endcase
    if (cmd.wr_prev && cell_index == IDX_W'(MAX_CHUNKS - 1)) begin
      entry_next = cmd.prev_val;
    end
    if (cmd.wr_cur && cell_index == '0) begin
      entry_next = cmd.cur_val;
    end
    if (cmd.wr_next && cell_index == IDX_W'(1)) begin
      entry_next = cmd.next_val;
    end
  end

  // Slot register; reset leaves one free chunk over the default pool.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= (cell_index == '0) ? home_entry : CHUNK_EMPTY;
    end else begin
      entry <= entry_next;
    end
  end

endmodule

`default_nettype wire

// File: design/ffa_ctrl.sv
// ----------------------------------------------------------------------------
// ffa_ctrl: request sequencer for the chunk ring
// Rotates the ring past the head slot, checks each entry for a fit or a
// matching offset, edits the entries around the head, and holds the chunk
// count, the free total and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_ctrl
  import ffa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              operation,
  input  wire logic [ADDR_W-1:0] request_bytes,
  input  wire logic [4:0]        align_log2,
  input  wire logic [ADDR_W-1:0] release_offset,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [ADDR_W-1:0]      granted_offset,
  output logic [1:0]             status,
  output logic [ADDR_W-1:0]      bytes_free,
  input  wire logic              cfg_we,
  input  wire logic [ADDR_W-1:0] cfg_wdata,
  input  wire chunk_t            prev_entry,
  input  wire chunk_t            cur_entry,
  input  wire chunk_t            next_entry,
  output cell_cmd_t              cmd
);

  ffa_state_t        state, state_next;
  logic [CNT_W-1:0]  rot, rot_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [ADDR_W-1:0] free_total, free_total_next;
  logic              searching, searching_next;
  logic [ADDR_W-1:0] pad, pad_next;
  logic [ADDR_W-1:0] res_granted, res_granted_next;
  logic [1:0]        res_status, res_status_next;
  logic              req_op;
  logic [ADDR_W-1:0] req_size;
  logic [4:0]        req_lg;
  logic [ADDR_W-1:0] req_offset;

  logic [ADDR_W-1:0] amask, pad_raw, scan_pad, leftover;
  logic [ADDR_W:0]   need;
  logic              fit, match_free, hit;
  logic              has_prev, has_next, need_ins, table_full;
  logic              merge_right, merge_left, go_merge, out_free;
  logic [CNT_W-1:0]  rot_plus;

  // Head slot checks.
  always_comb begin
    amask      = ~({ADDR_W{1'b1}} << req_lg);
    pad_raw    = (~cur_entry.start + ADDR_W'(1)) & amask;
    scan_pad   = (rot == '0) ? '0 : pad_raw;
    need       = {1'b0, scan_pad} + {1'b0, req_size};
    fit        = cur_entry.is_free && ({1'b0, cur_entry.length} >= need);
    match_free = (cur_entry.start == req_offset) && !cur_entry.is_free;
    hit        = searching && (rot < count) && ((req_op == OP_ALLOC) ? fit : match_free);
    rot_plus   = rot + CNT_W'(1);
    has_prev   = (rot != '0);
    has_next   = (rot_plus < count);
    leftover   = cur_entry.length - pad - req_size;
    need_ins   = (leftover != '0) && !(has_next && next_entry.is_free);
    table_full = (count == CNT_W'(MAX_CHUNKS));
    merge_right = has_next && next_entry.is_free;
    merge_left  = has_prev && prev_entry.is_free;
    go_merge    = (req_op == OP_FREE) && merge_left;
    out_free    = !out_valid || out_ready;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (rot == CNT_W'(MAX_CHUNKS)) state_next = ST_DONE;
        else if (hit) state_next = ST_EDIT;
      end
      ST_EDIT: begin
        state_next = go_merge ? ST_MERGE : ST_SCAN;
      end
      ST_MERGE: begin
        state_next = ST_SCAN;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Cell commands and register updates.
  always_comb begin
    cmd              = '0;
    cmd.mode         = CM_HOLD;
    cmd.pool         = cfg_wdata;
    in_ready         = (state == ST_IDLE);
    rot_next         = rot;
    count_next       = count;
    free_total_next  = free_total;
    searching_next   = searching;
    pad_next         = pad;
    res_granted_next = res_granted;
    res_status_next  = res_status;
    unique case (state)
      ST_IDLE: begin
        if (cfg_we) begin
          cmd.mode        = CM_INIT;
          count_next      = CNT_W'(1);
          free_total_next = cfg_wdata;
        end
        if (in_valid) begin
          rot_next         = '0;
          searching_next   = 1'b1;
          res_granted_next = '0;
          res_status_next  = (operation == OP_FREE) ? STAT_NOT_ALLOC : STAT_NO_FIT;
        end
      end
      ST_SCAN: begin
        if (rot != CNT_W'(MAX_CHUNKS)) begin
          if (hit) begin
            pad_next       = scan_pad;
            searching_next = 1'b0;
          end else begin
            cmd.mode = CM_ROT;
            rot_next = rot_plus;
          end
        end
      end
      ST_EDIT: begin
        if (req_op == OP_ALLOC) begin
          if (need_ins && table_full) begin
            res_status_next = STAT_FULL;
          end else begin
            res_status_next  = STAT_OK;
            res_granted_next = cur_entry.start + pad;
            cmd.wr_cur       = 1'b1;
            cmd.cur_val.start   = cur_entry.start + pad;
            cmd.cur_val.length  = req_size;
            cmd.cur_val.is_free = 1'b0;
            if (has_prev) begin
              cmd.wr_prev  = 1'b1;
              cmd.prev_val = prev_entry;
              cmd.prev_val.length = prev_entry.length + pad;
            end
            free_total_next = free_total - req_size
                              - ((has_prev && !prev_entry.is_free) ? pad : '0);
            if (leftover != '0) begin
              cmd.wr_next = 1'b1;
              if (!need_ins) begin
                cmd.next_val.start   = next_entry.start - leftover;
                cmd.next_val.length  = next_entry.length + leftover;
                cmd.next_val.is_free = 1'b1;
              end else begin
                cmd.mode = CM_INS;
                cmd.lim  = count - rot;
                cmd.next_val.start   = cur_entry.start + pad + req_size;
                cmd.next_val.length  = leftover;
                cmd.next_val.is_free = 1'b1;
                count_next = count + CNT_W'(1);
              end
            end
          end
        end else begin
          res_status_next  = STAT_OK;
          cmd.wr_cur       = 1'b1;
          cmd.cur_val.start   = cur_entry.start;
          cmd.cur_val.length  = cur_entry.length + (merge_right ? next_entry.length : '0);
          cmd.cur_val.is_free = 1'b1;
          free_total_next     = free_total + cur_entry.length;
          if (merge_right) begin
            cmd.mode         = CM_REM;
            cmd.rem_from_one = 1'b1;
            cmd.lim          = count - CNT_W'(1) - rot;
            count_next       = count - CNT_W'(1);
          end
        end
      end
      ST_MERGE: begin
        cmd.wr_prev  = 1'b1;
        cmd.prev_val = prev_entry;
        cmd.prev_val.length = prev_entry.length + cur_entry.length;
        cmd.mode     = CM_REM;
        cmd.lim      = count - CNT_W'(1) - rot;
        count_next   = count - CNT_W'(1);
      end
      ST_DONE: begin
        if (out_free) rot_next = '0;
      end
      default: begin
        cmd.mode = CM_HOLD;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      rot        <= '0;
      count      <= CNT_W'(1);
      free_total <= POOL_RESET;
      searching  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      rot        <= rot_next;
      count      <= count_next;
      free_total <= free_total_next;
      searching  <= searching_next;
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk) begin
    pad         <= pad_next;
    res_granted <= res_granted_next;
    res_status  <= res_status_next;
    if (state == ST_IDLE && in_valid) begin
      req_op     <= operation;
      req_size   <= request_bytes;
      req_lg     <= align_log2;
      req_offset <= release_offset;
    end
    if (state == ST_DONE && out_free) begin
      granted_offset <= res_granted;
      status         <= res_status;
      bytes_free     <= free_total;
    end
  end

  // A rotation always ends back at alignment.
  a_done_aligned: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE |-> rot == CNT_W'(MAX_CHUNKS))
    else $error("ring not aligned at end of request");

  // The table never becomes empty or overfull.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != '0 && count <= CNT_W'(MAX_CHUNKS))
    else $error("chunk count out of range");

  // A pool write leaves one chunk holding the whole pool as free space.
  a_cfg_init: assert property (@(posedge clk) disable iff (rst)
    cfg_we && state == ST_IDLE |=> count == CNT_W'(1) && free_total == $past(cfg_wdata))
    else $error("pool write did not reinitialize table");

  // An edit only follows a found entry within the chunk count.
  a_edit_found: assert property (@(posedge clk) disable iff (rst)
    state == ST_EDIT |-> !searching && rot < count)
    else $error("edit without a found entry");

endmodule

`default_nettype wire

// File: design/first_fit_aligned_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_aligned_allocator: first-fit allocator with alignment and merging
// A ring of chunk cells holds the ordered chunk table; a controller rotates
// it past a head slot to find a fit or an offset and edits in place.
//
//   channel | handshake          | payload
//   --------+--------------------+---------------------------------------------
//   in      | in_valid/in_ready  | operation, request_bytes, align_log2,
//           |                    | release_offset
//   out     | out_valid/out_ready| granted_offset, status, bytes_free
//   cfg     | cfg_we             | cfg_wdata (pool size)
//
// Each request makes one full turn of the cell ring, plus an edit step, a
// merge step when a freed chunk joins its left neighbor, and a result step.
// Inserts and removals shift the whole ring at once.
// Reset is synchronous and restores one free chunk of 65536 bytes.
// A stalled result waits in the output register; the next request is taken
// once that result has been loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_aligned_allocator
  import ffa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              operation,
  input  wire logic [ADDR_W-1:0] request_bytes,
  input  wire logic [4:0]        align_log2,
  input  wire logic [ADDR_W-1:0] release_offset,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [ADDR_W-1:0]      granted_offset,
  output logic [1:0]             status,
  output logic [ADDR_W-1:0]      bytes_free,
  input  wire logic              cfg_we,
  input  wire logic [ADDR_W-1:0] cfg_wdata
);

  chunk_t    cell_entry [MAX_CHUNKS];
  cell_cmd_t cmd;

  // Controller.
  ffa_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .operation      (operation),
    .request_bytes  (request_bytes),
    .align_log2     (align_log2),
    .release_offset (release_offset),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .granted_offset (granted_offset),
    .status         (status),
    .bytes_free     (bytes_free),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .prev_entry     (cell_entry[MAX_CHUNKS-1]),
    .cur_entry      (cell_entry[0]),
    .next_entry     (cell_entry[1]),
    .cmd            (cmd)
  );

  // Ring of cells, each wired to both neighbors.
  for (genvar g = 0; g < MAX_CHUNKS; g++) begin : g_cell
    ffa_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .cell_index  (IDX_W'(g)),
      .cmd         (cmd),
      .left_entry  (cell_entry[(g + MAX_CHUNKS - 1) % MAX_CHUNKS]),
      .right_entry (cell_entry[(g + 1) % MAX_CHUNKS]),
      .entry       (cell_entry[g])
    );
  end

endmodule

`default_nettype wire

// File: bench/alloc_checker.sv
// ----------------------------------------------------------------------------
// alloc_checker: result predictor and comparator for the allocator
// Watches the request, result and pool-size ports, keeps its own copy of the
// chunk table, predicts every result in order and compares field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module alloc_checker
  import ffa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              in_ready,
  input  wire logic              operation,
  input  wire logic [ADDR_W-1:0] request_bytes,
  input  wire logic [4:0]        align_log2,
  input  wire logic [ADDR_W-1:0] release_offset,
  input  wire logic              out_valid,
  input  wire logic              out_ready,
  input  wire logic [ADDR_W-1:0] granted_offset,
  input  wire logic [1:0]        status,
  input  wire logic [ADDR_W-1:0] bytes_free,
  input  wire logic              cfg_we,
  input  wire logic [ADDR_W-1:0] cfg_wdata,
  output int                     fail_count,
  output int                     results_owed
);

  typedef struct {
    logic [ADDR_W-1:0] offset;
    logic [1:0]        code;
    logic [ADDR_W-1:0] remaining;
  } grant_t;

  // Shadow chunk table, kept in 64 bits so sums never wrap.
  logic [63:0] shadow_start [MAX_CHUNKS];
  logic [63:0] shadow_len   [MAX_CHUNKS];
  bit          shadow_free  [MAX_CHUNKS];
  int          shadow_count;
  logic [63:0] shadow_avail;
  logic [63:0] shadow_pool;
  grant_t      grants_due [$];

  assign results_owed = grants_due.size();

  // Back to one free chunk spanning the pool.
  task automatic table_clear();
    for (int k = 0; k < MAX_CHUNKS; k++) begin
      shadow_start[k] = '0;
      shadow_len[k]   = '0;
      shadow_free[k]  = 1'b0;
    end
    shadow_len[0]  = shadow_pool;
    shadow_free[0] = 1'b1;
    shadow_count   = 1;
    shadow_avail   = shadow_pool;
  endtask

  // Drop one entry and close the gap.
  task automatic table_drop(input int pos);
    for (int k = pos; k + 1 < shadow_count; k++) begin
      shadow_start[k] = shadow_start[k+1];
      shadow_len[k]   = shadow_len[k+1];
      shadow_free[k]  = shadow_free[k+1];
    end
    shadow_start[shadow_count-1] = '0;
    shadow_len[shadow_count-1]   = '0;
    shadow_free[shadow_count-1]  = 1'b0;
    shadow_count--;
  endtask

  // First-fit allocation with padding handed to the previous chunk.
  task automatic grant_alloc(input logic [63:0] size, input int lg, output grant_t g);
    logic [63:0] align, amask, pad, spare;
    int          hit;
    bit          split;
    align = 64'd1 << lg;
    amask = align - 1;
    hit   = -1;
    pad   = '0;
    g.offset = '0;
    for (int i = 0; i < shadow_count; i++) begin
      pad = (align - (shadow_start[i] & amask)) & amask;
      if (shadow_free[i] && shadow_len[i] >= pad + size) begin
        hit = i;
        break;
      end
    end
    if (hit < 0) begin
      g.code = STAT_NO_FIT;
      return;
    end
    if (hit == 0) pad = '0;
    spare = shadow_len[hit] - pad - size;
    split = spare > 0 && !(hit + 1 < shadow_count && shadow_free[hit+1]);
    if (split && shadow_count >= MAX_CHUNKS) begin
      g.code = STAT_FULL;
      return;
    end
    if (hit > 0) begin
      shadow_len[hit-1] += pad;
      shadow_start[hit] += pad;
      if (!shadow_free[hit-1]) shadow_avail -= pad;
    end
    shadow_free[hit] = 1'b0;
    shadow_len[hit]  = size;
    if (spare > 0) begin
      if (!split) begin
        shadow_len[hit+1]   += spare;
        shadow_start[hit+1] -= spare;
      end else begin
        for (int k = shadow_count; k > hit + 1; k--) begin
          shadow_start[k] = shadow_start[k-1];
          shadow_len[k]   = shadow_len[k-1];
          shadow_free[k]  = shadow_free[k-1];
        end
        shadow_start[hit+1] = shadow_start[hit] + size;
        shadow_len[hit+1]   = spare;
        shadow_free[hit+1]  = 1'b1;
        shadow_count++;
      end
    end
    shadow_avail -= size;
    g.offset = shadow_start[hit][ADDR_W-1:0];
    g.code   = STAT_OK;
  endtask

  // Release the first allocated chunk at the offset and merge both ways.
  task automatic grant_release(input logic [63:0] where, output grant_t g);
    int hit;
    bit join_left, join_right;
    hit = -1;
    g.offset = '0;
    for (int i = 0; i < shadow_count; i++) begin
      if (shadow_start[i] == where && !shadow_free[i]) begin
        hit = i;
        break;
      end
    end
    if (hit < 0) begin
      g.code = STAT_NOT_ALLOC;
      return;
    end
    shadow_free[hit] = 1'b1;
    shadow_avail += shadow_len[hit];
    join_right = hit + 1 < shadow_count && shadow_free[hit+1];
    join_left  = hit > 0 && shadow_free[hit-1];
    if (join_right) begin
      shadow_len[hit] += shadow_len[hit+1];
      table_drop(hit + 1);
    end
    if (join_left) begin
      shadow_len[hit-1] += shadow_len[hit];
      table_drop(hit);
    end
    g.code = STAT_OK;
  endtask

  // Compare results first, then predict the request taken on the same edge.
  always @(posedge clk) begin
    grant_t want, got;
    if (rst) begin
      shadow_pool = 64'(POOL_RESET);
      table_clear();
      grants_due.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        shadow_pool = 64'(cfg_wdata);
        table_clear();
      end
      if (out_valid && out_ready) begin
        if (grants_due.size() == 0) begin
          $display("%0t: result with none expected: offset %h status %0d free %h",
                   $time, granted_offset, status, bytes_free);
          fail_count++;
        end else begin
          want = grants_due.pop_front();
          if (granted_offset !== want.offset) begin
            $display("%0t: granted_offset expected %h actual %h",
                     $time, want.offset, granted_offset);
            fail_count++;
          end
          if (status !== want.code) begin
            $display("%0t: status expected %0d actual %0d", $time, want.code, status);
            fail_count++;
          end
          if (bytes_free !== want.remaining) begin
            $display("%0t: bytes_free expected %h actual %h",
                     $time, want.remaining, bytes_free);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (operation == OP_ALLOC) grant_alloc(64'(request_bytes), int'(align_log2), got);
        else grant_release(64'(release_offset), got);
        got.remaining = shadow_avail[ADDR_W-1:0];
        grants_due.push_back(got);
      end
    end
  end

endmodule

`default_nettype wire

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the first-fit aligned allocator
// Drives directed and random allocate and free requests over several pool
// sizes, with random idling on both channels and one long result stall.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import ffa_pkg::*;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              operation = OP_ALLOC;
  logic [ADDR_W-1:0] request_bytes = '0;
  logic [4:0]        align_log2 = '0;
  logic [ADDR_W-1:0] release_offset = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [ADDR_W-1:0] granted_offset;
  logic [1:0]        status;
  logic [ADDR_W-1:0] bytes_free;
  logic              cfg_we = 1'b0;
  logic [ADDR_W-1:0] cfg_wdata = '0;
  int                fail_count;
  int                results_owed;

  bit                calm = 1'b0;
  bit                long_hold_req = 1'b0;
  int                hold_left = 0;
  int                sent = 0;
  int                returned = 0;
  int                n_full = 0, n_nofit = 0, n_badfree = 0, n_ok = 0;
  logic              ops_in_flight [$];
  logic [ADDR_W-1:0] live_blocks [$];
  logic [ADDR_W-1:0] pool_now = POOL_RESET;

  first_fit_aligned_allocator u_top (
    .clk, .rst, .in_valid, .in_ready, .operation, .request_bytes, .align_log2,
    .release_offset, .out_valid, .out_ready, .granted_offset, .status,
    .bytes_free, .cfg_we, .cfg_wdata
  );

  alloc_checker u_check (
    .clk, .rst, .in_valid, .in_ready, .operation, .request_bytes, .align_log2,
    .release_offset, .out_valid, .out_ready, .granted_offset, .status,
    .bytes_free, .cfg_we, .cfg_wdata, .fail_count, .results_owed
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Run limit.
  initial begin
    #12000000;
    $display("TEST FAILED");
    $finish;
  end

  // Result side: random stalls, plus one long hold on request.
  always @(posedge clk) begin
    if (long_hold_req) begin
      hold_left <= 600;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 21);
    end
  end

  // Track granted blocks so that most frees name a live one.
  always @(posedge clk) begin
    logic was_alloc;
    if (!rst && out_valid && out_ready && ops_in_flight.size() > 0) begin
      was_alloc = ops_in_flight.pop_front();
      returned++;
      case (status)
        STAT_OK: begin
          n_ok++;
          if (was_alloc == OP_ALLOC) live_blocks.push_back(granted_offset);
        end
        STAT_NO_FIT:    n_nofit++;
        STAT_NOT_ALLOC: n_badfree++;
        STAT_FULL:      n_full++;
        default: ;
      endcase
    end
  end

  // Offer one request and wait for its transfer.
  task automatic push_req(input logic op, input logic [ADDR_W-1:0] size,
                          input logic [4:0] lg, input logic [ADDR_W-1:0] where);
    if (!calm && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    operation      <= op;
    request_bytes  <= size;
    align_log2     <= lg;
    release_offset <= where;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ops_in_flight.push_back(op);
    sent++;
  endtask

  // Wait until every result is back.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (returned != sent || results_owed != 0) @(posedge clk);
  endtask

  // New pool size; only while the block is idle.
  task automatic set_pool(input logic [ADDR_W-1:0] bytes);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= bytes;
    @(posedge clk);
    cfg_we <= 1'b0;
    live_blocks.delete();
    pool_now = bytes;
  endtask

  // Random request shaped to the current pool.
  task automatic random_req(input int alloc_pct);
    logic [ADDR_W-1:0] size, where;
    logic [4:0]        lg;
    int                pick;
    if ($urandom_range(99) < alloc_pct) begin
      case ($urandom_range(9))
        0:       size = $urandom;
        1:       size = '0;
        default: size = $urandom_range(0, (pool_now > 64) ? pool_now / 12 : pool_now);
      endcase
      lg = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(6));
      push_req(OP_ALLOC, size, lg, $urandom);
    end else begin
      if (live_blocks.size() > 0 && $urandom_range(99) < 85) begin
        pick  = $urandom_range(live_blocks.size() - 1);
        where = live_blocks[pick];
        live_blocks.delete(pick);
      end else begin
        where = $urandom;
      end
      push_req(OP_FREE, $urandom, 5'($urandom_range(31)), where);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed cases on the reset pool, then on pools of 1 and 0xFFFFFFFF bytes.
    push_req(OP_ALLOC, 32'd0, 5'd0, '0);
    push_req(OP_ALLOC, 32'd100, 5'd0, '0);
    push_req(OP_ALLOC, 32'd10, 5'd8, '0);
    push_req(OP_ALLOC, 32'hFFFF_FFFF, 5'd0, '0);
    push_req(OP_ALLOC, 32'd1, 5'd31, '0);
    push_req(OP_ALLOC, 32'd0, 5'd4, 32'hFFFF_FFFF);
    push_req(OP_FREE, '0, 5'd0, 32'd0);
    push_req(OP_FREE, '0, 5'd0, 32'd0);
    push_req(OP_FREE, '0, 5'd0, 32'd0);
    push_req(OP_FREE, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF);
    push_req(OP_FREE, '0, 5'd0, 32'd256);
    push_req(OP_FREE, '0, 5'd0, 32'd100);
    push_req(OP_ALLOC, 32'd65536, 5'd0, '0);
    set_pool(32'd1);
    push_req(OP_ALLOC, 32'd2, 5'd0, '0);
    push_req(OP_ALLOC, 32'd1, 5'd0, '0);
    push_req(OP_ALLOC, 32'd0, 5'd3, '0);
    push_req(OP_FREE, '0, 5'd0, 32'd0);
    set_pool(32'hFFFF_FFFF);
    push_req(OP_ALLOC, 32'h0000_0003, 5'd0, '0);
    push_req(OP_ALLOC, 32'h8000_0000, 5'd31, '0);
    push_req(OP_ALLOC, 32'h7FFF_FFFC, 5'd0, '0);
    push_req(OP_FREE, '0, 5'd0, 32'h8000_0000);
    push_req(OP_FREE, '0, 5'd0, 32'd0);

    // Fill the table with small blocks until it overflows, then punch holes.
    set_pool(32'd65536);
    repeat (270) push_req(OP_ALLOC, $urandom_range(0, 8), 5'($urandom_range(2)), '0);
    settle();
    repeat (80) random_req(30);

    // Random phases over several pool sizes; one quiet stretch, one long stall.
    set_pool(32'd4096);
    calm = 1'b1;
    repeat (120) random_req(60);
    calm = 1'b0;
    long_hold_req <= 1'b1;
    @(posedge clk);
    long_hold_req <= 1'b0;
    repeat (100) random_req(60);
    set_pool(32'd1000);
    repeat (160) random_req(55);
    set_pool(32'hFFFF_FFFF);
    repeat (160) random_req(55);
    set_pool(32'd3);
    repeat (60) random_req(55);
    set_pool(32'd65536);
    repeat (200) random_req(65);

    settle();
    repeat (300) @(posedge clk);
    $display("Ran %0d requests over six pool sizes, with a full table and a long stall.",
             sent);
    $display("Outcomes: %0d ok, %0d no fit, %0d bad free, %0d table full.",
             n_ok, n_nofit, n_badfree, n_full);
    if (fail_count == 0 && results_owed == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
design/ffa_pkg.sv
design/ffa_cell.sv
design/ffa_ctrl.sv
design/first_fit_aligned_allocator.sv
bench/alloc_checker.sv
bench/tb.sv
